// File: hdl/hblt_pkg.sv
// Shared types and constants of the heartbeat liveness table.
`timescale 1ns / 1ps

package hblt_pkg;

	localparam int PORT_W      = 16;
	localparam int IVAL_W      = 16;
	localparam int DEC_W       = 16;
	localparam int TIMER_W     = 17;
	localparam int WORD_W      = TIMER_W + PORT_W;
	localparam int MAX_RESULTS = 16;
	localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
	localparam logic [DEC_W-1:0] DEC_RESET = DEC_W'(10);

	typedef enum logic [1:0] {
		OP_BEAT  = 2'd0,
		OP_STOP  = 2'd1,
		OP_TICK  = 2'd2,
		OP_RELAY = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ADDED      = 3'd0,
		ST_REFRESHED  = 3'd1,
		ST_FULL       = 3'd2,
		ST_STOPPED    = 3'd3,
		ST_STOP_MISS  = 3'd4,
		ST_TICK       = 3'd5,
		ST_RELAY_PORT = 3'd6,
		ST_RELAY_NONE = 3'd7
	} status_t;

	typedef struct packed {
		status_t           status;
		logic [PORT_W-1:0] port;
		logic              last;
	} result_t;

endpackage

// File: hdl/heartbeat_liveness_table.sv
// Top level of the heartbeat liveness table: slot memory, walk sequencer, result queue.
`timescale 1ns / 1ps

// Channel    | Direction | Payload                                          | Handshake
// s_*        | in        | tuser[1:0] op; tdata[15:0] client_port,          | s_tvalid/s_tready
//            |           | tdata[31:16] beat_interval                       |
// m_*        | out       | tuser[2:0] status; tdata[15:0] out_port; tlast   | m_tvalid/m_tready
// cfg_*      | in        | cfg_data[15:0] tick_decrement                    | cfg_valid/cfg_ready
//
// Each request passes through three states before the next request can be accepted:
// accept in idle, walk the slot memory through its single read port one slot a cycle
// while no relay result is held back, plus a drain step, then close.
// Reset clears the alive and used flags in flip-flops at once; no clearing pass.
// A stalled result output holds the walk only when a relay result must be queued;
// the next request is accepted while the final result still waits in the output.

module heartbeat_liveness_table #(
	parameter int NUM_ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,   // client_port, beat_interval
	input  logic [1:0]                    s_tuser,   // op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hblt_pkg::PORT_W-1:0]   m_tdata,   // out_port
	output logic [2:0]                    m_tuser,   // status
	output logic                          m_tlast,   // last
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hblt_pkg::DEC_W-1:0]    cfg_data   // tick_decrement
);
	import hblt_pkg::*;

	localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

	typedef enum logic [2:0] {
		FSM_IDLE  = 3'b001,
		FSM_WALK  = 3'b010,
		FSM_FINAL = 3'b100
	} fsm_t;

	fsm_t state_q;

	// Request registers
	op_t               op_q;
	logic [PORT_W-1:0] port_q;
	logic [IVAL_W-1:0] ival_q;
	logic [DEC_W-1:0]  dec_q;

	// Slot memory: {timer, port}. Timers are read only for alive slots, and a slot
	// turns alive only through a heartbeat that writes its word.
	logic [WORD_W-1:0] mem [NUM_ENTRIES];
	logic [WORD_W-1:0] rd_word_s1;
	logic              valid_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [CNT_W-1:0]  rd_cnt_q;

	logic [NUM_ENTRIES-1:0] alive_q;
	logic [NUM_ENTRIES-1:0] used_q;

	// Search results of the walk
	logic             match_found_q, free_found_q, dead_found_q;
	logic [IDX_W-1:0] match_idx_q, free_idx_q, dead_idx_q;

	// Relay: one port held back so the final one can carry last
	logic              pend_valid_q;
	logic [PORT_W-1:0] pend_port_q;
	logic [RCNT_W-1:0] rel_cnt_q;

	logic               walking, issue, adv, rd_en;
	logic               s1_used, s1_alive, s1_match;
	logic [PORT_W-1:0]  s1_port;
	logic [TIMER_W-1:0] s1_timer, dec_ext;
	logic               relay_hit, walk_push, tick_hit, tick_expire;
	logic               out_free, push, fin_go;
	result_t            push_res;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	logic [WORD_W-1:0]  wr_word;
	logic               hb_take;
	logic [IDX_W-1:0]   hb_idx;
	status_t            hb_status;

	assign s_tready  = (state_q == FSM_IDLE);
	assign cfg_ready = 1'b1;

	assign walking  = (state_q == FSM_WALK);
	assign issue    = walking && (rd_cnt_q < CNT_W'(NUM_ENTRIES));
	assign s1_used  = used_q[idx_s1];
	assign s1_alive = alive_q[idx_s1];
	assign s1_port  = rd_word_s1[PORT_W-1:0];
	assign s1_timer = rd_word_s1[WORD_W-1:PORT_W];
	assign s1_match = valid_s1 && s1_used && (s1_port == port_q);
	assign dec_ext  = {{(TIMER_W-DEC_W){1'b0}}, dec_q};

	assign relay_hit = walking && valid_s1 && (op_q == OP_RELAY) && s1_alive
		&& (rel_cnt_q < RCNT_W'(MAX_RESULTS));
	assign walk_push = relay_hit && pend_valid_q;
	// Hold the walk only while a relay result cannot be queued
	assign adv   = !(walk_push && !out_free);
	assign rd_en = issue && adv;

	assign tick_hit    = walking && valid_s1 && (op_q == OP_TICK) && s1_alive && adv;
	assign tick_expire = (s1_timer <= dec_ext);

	// Heartbeat slot choice: matching slot, else lowest unused, else lowest dead
	always_comb begin
		hb_take   = 1'b1;
		hb_idx    = match_idx_q;
		hb_status = ST_REFRESHED;
		if (!match_found_q) begin
			hb_status = ST_ADDED;
			if (free_found_q) begin
				hb_idx = free_idx_q;
			end else if (dead_found_q) begin
				hb_idx = dead_idx_q;
			end else begin
				hb_take   = 1'b0;
				hb_status = ST_FULL;
			end
		end
	end

	assign fin_go = (state_q == FSM_FINAL) && out_free;

	// Result to queue: a held relay port while walking, else the closing result
	always_comb begin
		push_res.status = ST_TICK;
		push_res.port   = '0;
		push_res.last   = 1'b1;
		if (walking) begin
			push_res.status = ST_RELAY_PORT;
			push_res.port   = pend_port_q;
			push_res.last   = 1'b0;
		end else begin
			case (op_q)
				OP_BEAT: push_res.status = hb_status;
				OP_STOP: push_res.status = match_found_q ? ST_STOPPED : ST_STOP_MISS;
				OP_TICK: push_res.status = ST_TICK;
				OP_RELAY: begin
					if (pend_valid_q) begin
						push_res.status = ST_RELAY_PORT;
						push_res.port   = pend_port_q;
					end else begin
						push_res.status = ST_RELAY_NONE;
					end
				end
				default: push_res.status = ST_TICK;
			endcase
		end
	end

	assign push = (walk_push && out_free) || fin_go;

	// Memory write: tick write-back during the walk, heartbeat load at the close
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = idx_s1;
		wr_word = rd_word_s1;
		if (tick_hit) begin
			wr_en   = 1'b1;
			wr_word = {tick_expire ? TIMER_W'(0) : (s1_timer - dec_ext), s1_port};
		end else if (fin_go && (op_q == OP_BEAT) && hb_take) begin
			wr_en   = 1'b1;
			wr_idx  = hb_idx;
			wr_word = {ival_q, 1'b0, port_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_word;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word_s1 <= mem[rd_cnt_q[IDX_W-1:0]];
			idx_s1     <= rd_cnt_q[IDX_W-1:0];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FSM_IDLE;
			rd_cnt_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			case (state_q)
				FSM_IDLE: begin
					if (s_tvalid) begin
						state_q  <= FSM_WALK;
						rd_cnt_q <= '0;
						valid_s1 <= 1'b0;
					end
				end
				FSM_WALK: begin
					if (adv) begin
						valid_s1 <= issue;
						if (issue) begin
							rd_cnt_q <= rd_cnt_q + CNT_W'(1);
						end else if (!valid_s1) begin
							state_q <= FSM_FINAL;
						end
					end
				end
				FSM_FINAL: begin
					if (out_free) begin
						state_q <= FSM_IDLE;
					end
				end
				default: state_q <= FSM_IDLE;
			endcase
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q   <= op_t'(s_tuser);
			port_q <= s_tdata[PORT_W-1:0];
			ival_q <= s_tdata[PORT_W+IVAL_W-1:PORT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q <= DEC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dec_q <= cfg_data;
		end
	end

	// Walk bookkeeping: first match, first unused, first dead; relay hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			dead_found_q  <= 1'b0;
			pend_valid_q  <= 1'b0;
			rel_cnt_q     <= '0;
		end else if (s_tvalid && s_tready) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			dead_found_q  <= 1'b0;
			pend_valid_q  <= 1'b0;
			rel_cnt_q     <= '0;
		end else if (walking && valid_s1 && adv) begin
			if (s1_match && !match_found_q) begin
				match_found_q <= 1'b1;
			end
			if (!s1_used && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			if (!s1_alive && !dead_found_q) begin
				dead_found_q <= 1'b1;
			end
			if (relay_hit) begin
				pend_valid_q <= 1'b1;
				rel_cnt_q    <= rel_cnt_q + RCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (walking && valid_s1 && adv) begin
			if (s1_match && !match_found_q) begin
				match_idx_q <= idx_s1;
			end
			if (!s1_used && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
			if (!s1_alive && !dead_found_q) begin
				dead_idx_q <= idx_s1;
			end
			if (relay_hit) begin
				pend_port_q <= s1_port;
			end
		end
	end

	// Liveness flags: tick expiry during the walk, heartbeat and stop at the close
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '0;
			used_q  <= '0;
		end else begin
			if (tick_hit && tick_expire) begin
				alive_q[idx_s1] <= 1'b0;
			end
			if (fin_go && (op_q == OP_BEAT) && hb_take) begin
				alive_q[hb_idx] <= 1'b1;
				used_q[hb_idx]  <= 1'b1;
			end
			if (fin_go && (op_q == OP_STOP) && match_found_q) begin
				alive_q[match_idx_q] <= 1'b0;
			end
		end
	end

	hblt_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.result   (push_res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// A result is queued only into a free output register
	assert property (@(posedge clk) disable iff (!arst_n) push |-> out_free)
		else $error("result queued into a full output register");

	// An alive slot is always a used slot
	assert property (@(posedge clk) disable iff (!arst_n) (alive_q & ~used_q) == '0)
		else $error("alive flag set on an unused slot");

	// An accepted request always starts a walk
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == FSM_WALK && rd_cnt_q == '0))
		else $error("accepted request did not start a walk");

	// Relay never lists more than the result limit
	assert property (@(posedge clk) disable iff (!arst_n)
		rel_cnt_q <= RCNT_W'(MAX_RESULTS))
		else $error("relay count beyond limit");

endmodule

// File: hdl/hblt_out_reg.sv
// Output holding register for result requests.
`timescale 1ns / 1ps

module hblt_out_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  hblt_pkg::result_t             result,
	output logic                          free,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hblt_pkg::PORT_W-1:0]   m_tdata,  // out_port
	output logic [2:0]                    m_tuser,  // status
	output logic                          m_tlast   // last
);
	import hblt_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= result;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q.port;
	assign m_tuser  = data_q.status;
	assign m_tlast  = data_q.last;

endmodule

// File: tb/heartbeat_liveness_table_tb.sv
// Self-checking testbench for the heartbeat liveness table: directed and random requests.
`timescale 1ns / 1ps

module heartbeat_liveness_table_tb;
	import hblt_pkg::*;

	localparam int SLOTS          = 16;
	localparam int POOL           = 24;     // ports reused within one phase
	localparam int PHASES         = 7;
	localparam int PHASE_REQUESTS = 58;
	localparam int BACKLOG_CYCLES = 150;    // long receiver hold-off
	localparam int SETTLE_CYCLES  = 40;     // settling time at the end of the run
	localparam int CYCLE_LIMIT    = 200000;

	// Mirror of the slot table; predicts the results of each accepted request.
	class liveness_scoreboard;
		logic [PORT_W-1:0]  port_of [SLOTS];
		logic [TIMER_W-1:0] timer_of [SLOTS];
		bit                 alive [SLOTS];
		bit                 used [SLOTS];
		logic [DEC_W-1:0]   decrement;
		result_t            awaited_results [$];
		int                 mismatches;
		int                 results_checked;
		int                 status_count [8];

		function new();
			decrement = DEC_RESET;
			foreach (alive[i]) begin
				alive[i]    = 1'b0;
				used[i]     = 1'b0;
				timer_of[i] = '0;
			end
		endfunction

		function int find_port(logic [PORT_W-1:0] p);
			for (int i = 0; i < SLOTS; i++)
				if (used[i] && port_of[i] == p)
					return i;
			return -1;
		endfunction

		function void set_decrement(logic [DEC_W-1:0] v);
			decrement = v;
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		function void note_request(op_t op, logic [PORT_W-1:0] p, logic [IVAL_W-1:0] ival);
			int      slot;
			int      live;
			int      listed;
			status_t st;
			result_t r;
			case (op)
				OP_BEAT: begin
					st   = ST_REFRESHED;
					slot = find_port(p);
					if (slot < 0) begin
						st = ST_ADDED;
						for (int i = 0; i < SLOTS; i++)
							if (slot < 0 && !used[i])
								slot = i;
						for (int i = 0; i < SLOTS; i++)
							if (slot < 0 && !alive[i])
								slot = i;
						if (slot < 0) begin
							st = ST_FULL;
						end else begin
							used[slot]    = 1'b1;
							port_of[slot] = p;
						end
					end
					if (slot >= 0) begin
						timer_of[slot] = {ival, 1'b0};
						alive[slot]    = 1'b1;
					end
					r = '{st, '0, 1'b1};
					awaited_results.push_back(r);
				end
				OP_STOP: begin
					slot = find_port(p);
					if (slot >= 0)
						alive[slot] = 1'b0;
					r = '{(slot >= 0) ? ST_STOPPED : ST_STOP_MISS, '0, 1'b1};
					awaited_results.push_back(r);
				end
				OP_TICK: begin
					foreach (alive[i]) begin
						if (alive[i]) begin
							if (timer_of[i] <= {1'b0, decrement}) begin
								timer_of[i] = '0;
								alive[i]    = 1'b0;
							end else begin
								timer_of[i] = timer_of[i] - {1'b0, decrement};
							end
						end
					end
					r = '{ST_TICK, '0, 1'b1};
					awaited_results.push_back(r);
				end
				default: begin
					live = 0;
					foreach (alive[i])
						if (alive[i])
							live++;
					if (live > MAX_RESULTS)
						live = MAX_RESULTS;
					listed = 0;
					for (int i = 0; i < SLOTS && listed < live; i++) begin
						if (alive[i]) begin
							listed++;
							r = '{ST_RELAY_PORT, port_of[i], listed == live};
							awaited_results.push_back(r);
						end
					end
					if (live == 0) begin
						r = '{ST_RELAY_NONE, '0, 1'b1};
						awaited_results.push_back(r);
					end
				end
			endcase
		endfunction

		function void check_result(status_t st, logic [PORT_W-1:0] p, logic l);
			result_t want;
			results_checked++;
			status_count[st]++;
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result %0d arrived with none awaited: status %s port %h last %b",
						results_checked, st.name(), p, l);
				return;
			end
			want = awaited_results.pop_front();
			if (want.status !== st || want.port !== p || want.last !== l) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result %0d: expected status %s port %h last %b, got status %s port %h last %b",
						results_checked, want.status.name(), want.port, want.last,
						st.name(), p, l);
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [31:0]       s_tdata;
	logic [1:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [PORT_W-1:0] m_tdata;
	logic [2:0]        m_tuser;
	logic              m_tlast;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [DEC_W-1:0]  cfg_data;

	liveness_scoreboard board = new();

	bit steady       = 1'b0;   // no idling on either side once set
	bit backlog_req  = 1'b0;   // toggle to ask the receiver for a long hold-off
	bit backlog_seen = 1'b0;
	int stall_left   = 0;
	int cycle_count  = 0;
	int requests_sent = 0;
	int settings_used = 1;

	heartbeat_liveness_table #(
		.NUM_ENTRIES(SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Watchdog: abort a run that hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: check every accepted result, then pick the next tready.
	// A long hold-off starts whenever backlog_req toggles; otherwise drop
	// tready in short random bursts unless the run is in its steady part.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(status_t'(m_tuser), m_tdata, m_tlast);
		if (backlog_seen != backlog_req) begin
			backlog_seen <= backlog_req;
			stall_left   <= BACKLOG_CYCLES;
			m_tready     <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (!steady && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 2);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Offer one request and hold it until the block takes it. Leave tvalid
	// high on return so back-to-back requests follow without a gap in tvalid.
	task automatic send_request(op_t op, logic [PORT_W-1:0] p, logic [IVAL_W-1:0] ival);
		if (!steady && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {ival, p};
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_request(op, p, ival);
		requests_sent++;
	endtask

	// Drop tvalid and wait until every awaited result has come back.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// Write tick_decrement; only called while the table is idle.
	task automatic write_decrement(logic [DEC_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		board.set_decrement(v);
		settings_used++;
	endtask

	// Random traffic over a small pool of ports so that heartbeats, stops and
	// refreshes hit the same slots and the table fills; a few fresh ports and
	// full-range intervals add noise and cover every data bit.
	task automatic run_phase(int count);
		logic [PORT_W-1:0] pool [POOL];
		logic [PORT_W-1:0] p;
		logic [IVAL_W-1:0] ival;
		int                pick;
		op_t               op;
		foreach (pool[i])
			pool[i] = PORT_W'($urandom);
		pool[0] = '0;
		pool[1] = '1;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 7) == 0)
				p = PORT_W'($urandom);
			else
				p = pool[$urandom_range(0, POOL - 1)];
			case ($urandom_range(0, 7))
				0:       ival = '0;
				1:       ival = '1;
				2:       ival = IVAL_W'($urandom);
				default: ival = IVAL_W'($urandom_range(1, 40));
			endcase
			if (pick < 45)
				op = OP_BEAT;
			else if (pick < 60)
				op = OP_STOP;
			else if (pick < 80)
				op = OP_TICK;
			else
				op = OP_RELAY;
			send_request(op, p, ival);
		end
	endtask

	initial begin
		logic [DEC_W-1:0] dec;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= OP_BEAT;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the reset decrement of ten.
		send_request(OP_RELAY, 16'h0000, 16'h0000);   // empty table: relay none
		send_request(OP_STOP,  16'h1234, 16'h0000);   // stop on empty table: miss
		send_request(OP_TICK,  16'h0000, 16'h0000);   // tick with nothing alive
		send_request(OP_BEAT,  16'h0000, 16'h0000);   // zero interval, port zero
		send_request(OP_BEAT,  16'hFFFF, 16'hFFFF);   // largest timer
		send_request(OP_BEAT,  16'hFFFF, 16'h0005);   // refresh, timer equals decrement
		send_request(OP_RELAY, 16'h0000, 16'h0000);   // two ports in slot order
		send_request(OP_TICK,  16'h0000, 16'h0000);   // both timers at or below the decrement: dead
		send_request(OP_RELAY, 16'h0000, 16'h0000);   // nothing alive again
		send_request(OP_BEAT,  16'hFFFF, 16'hAAAA);   // revive a dead entry: refreshed
		send_request(OP_BEAT,  16'h5555, 16'h0003);   // new port takes an unused slot
		send_request(OP_STOP,  16'hFFFF, 16'h0000);   // stopped
		send_request(OP_STOP,  16'hFFFF, 16'h0000);   // stop an already dead entry
		send_request(OP_STOP,  16'h5556, 16'h0000);   // near miss
		send_request(OP_RELAY, 16'h0000, 16'h0000);   // single port with last set
		send_request(OP_BEAT,  16'h8000, 16'h8000);
		settle();

		// Random phases, one decrement setting each: the reset value, the
		// extremes, zero, and a few others. The second phase starts with a
		// long receiver hold-off so the output backs up into the input.
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 1)
				backlog_req <= ~backlog_req;
			if (ph == PHASES - 1)
				steady <= 1'b1;
			case (ph)
				1:       dec = 16'd1;
				2:       dec = 16'hFFFF;
				3:       dec = 16'd0;
				4:       dec = DEC_W'($urandom_range(1, 65535));
				5:       dec = DEC_W'($urandom_range(2, 200));
				default: dec = DEC_RESET;
			endcase
			if (ph > 0)
				write_decrement(dec);
			run_phase(PHASE_REQUESTS);
			settle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d requests under %0d decrement settings, %0d results checked.",
			requests_sent, settings_used, board.results_checked);
		$display("Saw %0d table-full replies, %0d relayed ports, %0d stop misses.",
			board.status_count[ST_FULL], board.status_count[ST_RELAY_PORT],
			board.status_count[ST_STOP_MISS]);
		if (board.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
